FILE: rtl/core/rmj_pkg.sv
// rmj_pkg: payload structs, pipeline sideband structs and quotient helpers
// for the radar measurement jacobian pipeline; depends on nothing
package rmj_pkg;

	localparam int DATA_W = 32;
	localparam int QUO_W  = 31;
	localparam int WIDE_W = 64;
	localparam int PROD_W = 96;

	typedef struct packed {
		logic signed [DATA_W-1:0] pos_x;
		logic signed [DATA_W-1:0] pos_y;
		logic signed [DATA_W-1:0] vel_x;
		logic signed [DATA_W-1:0] vel_y;
	} state_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] range_d_px;
		logic signed [DATA_W-1:0] range_d_py;
		logic signed [DATA_W-1:0] bearing_d_px;
		logic signed [DATA_W-1:0] bearing_d_py;
		logic signed [DATA_W-1:0] rate_d_px;
		logic signed [DATA_W-1:0] rate_d_py;
		logic signed [DATA_W-1:0] rate_d_vx;
		logic signed [DATA_W-1:0] rate_d_vy;
		logic                     near_zero;
	} jac_t;

	// unsaturated quotient: sign, overflow (magnitude 2^31 or more) and low bits
	typedef struct packed {
		logic             neg;
		logic             ovf;
		logic [QUO_W-1:0] q;
	} quo_t;

	// carried alongside the square root
	typedef struct packed {
		logic              near;
		logic              pneg;
		logic              qneg;
		logic [DATA_W-1:0] ap;
		logic [DATA_W-1:0] aq;
		logic [WIDE_W-1:0] c1;
		logic [WIDE_W-1:0] ad;
		logic              dneg;
	} geo_t;

	// carried alongside the wide multiply
	typedef struct packed {
		logic              near;
		quo_t              e0;
		quo_t              e1;
		quo_t              e2;
		quo_t              e3;
		logic [WIDE_W-1:0] c1;
		logic              neg5;
	} mid_t;

	// carried alongside the range-rate divide
	typedef struct packed {
		logic near;
		quo_t e0;
		quo_t e1;
		quo_t e2;
		quo_t e3;
		logic neg5;
	} fin_t;

	function automatic logic [DATA_W-1:0] quo_mag(quo_t v);
		logic [DATA_W-1:0] m;
		if (v.ovf) begin
			m = v.neg ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
		end else begin
			m = {1'b0, v.q};
		end
		return m;
	endfunction

	function automatic logic quo_is_neg(quo_t v);
		return v.neg && (v.ovf || (v.q != '0));
	endfunction

	function automatic logic signed [DATA_W-1:0] quo_sat(quo_t v);
		logic [DATA_W-1:0] m;
		m = quo_mag(v);
		return $signed(v.neg ? (~m + {{(DATA_W-1){1'b0}}, 1'b1}) : m);
	endfunction

endpackage

FILE: rtl/core/rmj_sqrt.sv
// rmj_sqrt: fully pipelined 64-bit integer square root, one result bit a stage,
// with a sideband vector that travels with each transaction; uses rmj_pkg
module rmj_sqrt #(
	parameter int SW = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [rmj_pkg::WIDE_W-1:0]  rad,
	input  logic [SW-1:0]               in_side,
	output logic                        out_valid,
	output logic [rmj_pkg::DATA_W-1:0]  root,
	output logic [SW-1:0]               out_side
);

	localparam int W  = rmj_pkg::WIDE_W;
	localparam int NS = W / 2;

	logic          vld_s  [NS];
	logic [W-1:0]  x_s    [NS];
	logic [W-1:0]  r_s    [NS];
	logic [SW-1:0] side_s [NS];

	logic          vi [NS];
	logic [W-1:0]  xi [NS];
	logic [W-1:0]  ri [NS];
	logic [SW-1:0] si [NS];

	assign vi[0] = in_valid;
	assign xi[0] = rad;
	assign ri[0] = '0;
	assign si[0] = in_side;

	for (genvar k = 0; k < NS; k++) begin : g_stage
		localparam logic [W-1:0] BIT = W'(1) << (2 * (NS - 1 - k));
		logic [W:0]   sum;
		logic         ge;
		logic [W-1:0] x_n;
		logic [W-1:0] r_n;

		if (k > 0) begin : g_link
			assign vi[k] = vld_s[k-1];
			assign xi[k] = x_s[k-1];
			assign ri[k] = r_s[k-1];
			assign si[k] = side_s[k-1];
		end

		always_comb begin
			sum = {1'b0, ri[k]} + {1'b0, BIT};
			ge  = {1'b0, xi[k]} >= sum;
			x_n = ge ? (xi[k] - sum[W-1:0]) : xi[k];
			r_n = ge ? ((ri[k] >> 1) + BIT) : (ri[k] >> 1);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vi[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k]    <= x_n;
				r_s[k]    <= r_n;
				side_s[k] <= si[k];
			end
		end
	end

	assign out_valid = vld_s[NS-1];
	assign root      = r_s[NS-1][rmj_pkg::DATA_W-1:0];
	assign out_side  = side_s[NS-1];

endmodule

FILE: rtl/core/rmj_div.sv
// rmj_div: pipelined restoring divider, overflow check then one quotient bit
// a stage, sideband travels with each transaction; uses rmj_pkg
module rmj_div #(
	parameter int NW = 48,
	parameter int DW = 32,
	parameter int SW = 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [NW-1:0]              num,
	input  logic [DW-1:0]              den,
	input  logic [SW-1:0]              in_side,
	output logic                       out_valid,
	output logic                       out_ovf,
	output logic [rmj_pkg::QUO_W-1:0]  out_q,
	output logic [SW-1:0]              out_side
);

	localparam int QW = rmj_pkg::QUO_W;
	localparam int CW = (NW > DW + QW) ? NW : DW + QW;
	localparam int NS = QW + 1;

	logic          vld_s  [NS];
	logic [NW-1:0] rem_s  [NS];
	logic [DW-1:0] den_s  [NS];
	logic [QW-1:0] q_s    [NS];
	logic          ovf_s  [NS];
	logic [SW-1:0] side_s [NS];

	// quotient of 2^31 or more saturates downstream
	logic ovf0;
	assign ovf0 = (CW'(num) >> QW) >= CW'(den);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= num;
			den_s[0]  <= den;
			q_s[0]    <= '0;
			ovf_s[0]  <= ovf0;
			side_s[0] <= in_side;
		end
	end

	for (genvar k = 1; k < NS; k++) begin : g_stage
		localparam int BIT = QW - k;
		logic [CW-1:0] trial;
		logic [CW-1:0] rem_x;
		logic          ge;

		always_comb begin
			trial = CW'(den_s[k-1]) << BIT;
			rem_x = CW'(rem_s[k-1]);
			ge    = rem_x >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? NW'(rem_x - trial) : rem_s[k-1];
				den_s[k]  <= den_s[k-1];
				q_s[k]    <= q_s[k-1] | (QW'(ge) << BIT);
				ovf_s[k]  <= ovf_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_valid = vld_s[NS-1];
	assign out_ovf   = ovf_s[NS-1];
	assign out_q     = q_s[NS-1];
	assign out_side  = side_s[NS-1];

endmodule

FILE: rtl/core/rmj_wmul.sv
// rmj_wmul: two-stage 32 x 64 unsigned multiply built from two 32 x 32
// partial products, sideband travels alongside; uses rmj_pkg
module rmj_wmul #(
	parameter int SW = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [rmj_pkg::DATA_W-1:0]  a,
	input  logic [rmj_pkg::WIDE_W-1:0]  b,
	input  logic [SW-1:0]               in_side,
	output logic                        out_valid,
	output logic [rmj_pkg::PROD_W-1:0]  prod,
	output logic [SW-1:0]               out_side
);

	localparam int BW = rmj_pkg::WIDE_W;
	localparam int PW = rmj_pkg::PROD_W;
	localparam int HW = BW / 2;

	logic          vld_s1, vld_s2;
	logic [BW-1:0] lo_s1, hi_s1;
	logic [SW-1:0] side_s1, side_s2;
	logic [PW-1:0] prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s1   <= BW'(a) * BW'(b[HW-1:0]);
			hi_s1   <= BW'(a) * BW'(b[BW-1:HW]);
			side_s1 <= in_side;
			prod_s2 <= PW'(lo_s1) + (PW'(hi_s1) << HW);
			side_s2 <= side_s1;
		end
	end

	assign out_valid = vld_s2;
	assign prod      = prod_s2;
	assign out_side  = side_s2;

endmodule

FILE: rtl/core/radar_measurement_jacobian.sv
// radar_measurement_jacobian: top level of the radar range / bearing / range-rate
// jacobian pipeline; uses rmj_pkg, rmj_sqrt, rmj_div and rmj_wmul
//
// usage
//  - state channel (state_valid / state_stall / state) takes one (px, py, vx, vy)
//    transaction in signed Q.F; jac channel (jac_valid / jac_stall / jac) returns
//    the eight jacobian entries and the near_zero flag, one result per state
//  - threshold channel (thr_valid / thr_ready / thr_data) writes the near-zero
//    limit; thr_ready is always high, write it only while the pipeline is empty
//  - from acceptance to jac_valid a transaction passes two front stages,
//    32 square-root stages, 32 divider stages, two multiply stages, 32 more
//    divider stages and the output register
//  - throughput is one transaction per cycle; every stage is a plain register
//    with a valid bit, so the long dividers and the square root set latency only
//  - when jac_valid is high and jac_stall is asserted the whole pipeline holds
//    and state_stall rises in the same cycle; nothing is dropped or repeated
//  - reset empties the pipeline (all valid bits clear) and loads the threshold
//    with 66, about 0.001 at sixteen fraction bits
module radar_measurement_jacobian #(
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        state_valid,
	output logic                        state_stall,
	input  rmj_pkg::state_t             state,
	output logic                        jac_valid,
	input  logic                        jac_stall,
	output rmj_pkg::jac_t               jac,
	input  logic                        thr_valid,
	output logic                        thr_ready,
	input  logic [rmj_pkg::DATA_W-1:0]  thr_data
);

	localparam int DW    = rmj_pkg::DATA_W;
	localparam int WW    = rmj_pkg::WIDE_W;
	localparam int PW    = rmj_pkg::PROD_W;
	localparam int QW    = rmj_pkg::QUO_W;
	localparam int NW_R  = DW + FRAC_BITS;
	localparam int NW_C  = DW + 2 * FRAC_BITS;
	localparam int GEO_W = $bits(rmj_pkg::geo_t);
	localparam int MID_W = $bits(rmj_pkg::mid_t);
	localparam int FIN_W = $bits(rmj_pkg::fin_t);
	localparam logic [DW-1:0] THR_RESET = DW'(66);

	// global advance: the pipe moves unless a held result is being stalled
	logic adv;
	logic jac_valid_q;
	rmj_pkg::jac_t jac_q;

	assign adv         = !jac_valid_q || !jac_stall;
	assign state_stall = !adv;
	assign jac_valid   = jac_valid_q;
	assign jac         = jac_q;

	// threshold register, to be written only while idle; the block does not enforce it
	logic [DW-1:0] thr_q;
	assign thr_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (thr_valid) begin
			thr_q <= thr_data;
		end
	end

	// front stage 1: the four 32 x 32 products
	logic                 vld_s1;
	logic signed [DW-1:0] p_s1, q_s1;
	logic signed [WW-1:0] pp_s1, qq_s1, uq_s1, vp_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= state_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1  <= state.pos_x;
			q_s1  <= state.pos_y;
			pp_s1 <= WW'(state.pos_x) * WW'(state.pos_x);
			qq_s1 <= WW'(state.pos_y) * WW'(state.pos_y);
			uq_s1 <= WW'(state.vel_x) * WW'(state.pos_y);
			vp_s1 <= WW'(state.vel_y) * WW'(state.pos_x);
		end
	end

	// front stage 2: c1, the cross term d, magnitudes and the near-zero test
	logic                 vld_s2;
	logic [WW-1:0]        c1_s2;
	logic signed [WW:0]   d_s2;
	logic                 near_s2;
	logic [DW-1:0]        ap_s2, aq_s2;
	logic                 pneg_s2, qneg_s2;
	logic [WW-1:0]        c1_n;
	logic [WW-1:0]        thr_sh;

	always_comb begin
		c1_n   = $unsigned(pp_s1) + $unsigned(qq_s1);
		thr_sh = WW'(thr_q) << FRAC_BITS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c1_s2   <= c1_n;
			d_s2    <= {uq_s1[WW-1], uq_s1} - {vp_s1[WW-1], vp_s1};
			near_s2 <= c1_n <= thr_sh;
			ap_s2   <= p_s1[DW-1] ? DW'(-p_s1) : $unsigned(p_s1);
			aq_s2   <= q_s1[DW-1] ? DW'(-q_s1) : $unsigned(q_s1);
			pneg_s2 <= p_s1[DW-1];
			qneg_s2 <= q_s1[DW-1];
		end
	end

	// square root of c1, the rest rides along
	rmj_pkg::geo_t   geo_in, geo_out;
	logic [GEO_W-1:0] geo_vec;
	logic            sq_valid;
	logic [DW-1:0]   sq_root;
	logic signed [WW:0] d_neg;

	always_comb begin
		d_neg         = -d_s2;
		geo_in.near   = near_s2;
		geo_in.pneg   = pneg_s2;
		geo_in.qneg   = qneg_s2;
		geo_in.ap     = ap_s2;
		geo_in.aq     = aq_s2;
		geo_in.c1     = c1_s2;
		geo_in.ad     = d_s2[WW] ? d_neg[WW-1:0] : d_s2[WW-1:0];
		geo_in.dneg   = d_s2[WW];
	end

	rmj_sqrt #(.SW(GEO_W)) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s2),
		.rad       (c1_s2),
		.in_side   (geo_in),
		.out_valid (sq_valid),
		.root      (sq_root),
		.out_side  (geo_vec)
	);

	assign geo_out = rmj_pkg::geo_t'(geo_vec);

	// four parallel divides: px/c2, py/c2, py/c1, px/c1
	logic             da_valid;
	logic [GEO_W-1:0] da_side;
	logic [3:0]       da_ovf;
	logic [QW-1:0]    da_q [4];

	rmj_div #(.NW(NW_R), .DW(DW), .SW(GEO_W)) u_div_e0 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (sq_valid),
		.num       ({geo_out.ap, {FRAC_BITS{1'b0}}}),
		.den       (sq_root),
		.in_side   (geo_vec),
		.out_valid (da_valid),
		.out_ovf   (da_ovf[0]),
		.out_q     (da_q[0]),
		.out_side  (da_side)
	);

	rmj_div #(.NW(NW_R), .DW(DW), .SW(1)) u_div_e1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (sq_valid),
		.num       ({geo_out.aq, {FRAC_BITS{1'b0}}}),
		.den       (sq_root),
		.in_side   (1'b0),
		.out_valid (),
		.out_ovf   (da_ovf[1]),
		.out_q     (da_q[1]),
		.out_side  ()
	);

	rmj_div #(.NW(NW_C), .DW(WW), .SW(1)) u_div_e2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (sq_valid),
		.num       ({geo_out.aq, {(2 * FRAC_BITS){1'b0}}}),
		.den       (geo_out.c1),
		.in_side   (1'b0),
		.out_valid (),
		.out_ovf   (da_ovf[2]),
		.out_q     (da_q[2]),
		.out_side  ()
	);

	rmj_div #(.NW(NW_C), .DW(WW), .SW(1)) u_div_e3 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (sq_valid),
		.num       ({geo_out.ap, {(2 * FRAC_BITS){1'b0}}}),
		.den       (geo_out.c1),
		.in_side   (1'b0),
		.out_valid (),
		.out_ovf   (da_ovf[3]),
		.out_q     (da_q[3]),
		.out_side  ()
	);

	// quotients with their signs; range-rate signs from the sign of d
	rmj_pkg::geo_t g3;
	rmj_pkg::quo_t qa0, qa1, qa2, qa3;
	rmj_pkg::mid_t mid_in;
	logic          neg4, neg5;

	always_comb begin
		g3      = rmj_pkg::geo_t'(da_side);
		qa0.neg = g3.pneg;
		qa0.ovf = da_ovf[0];
		qa0.q   = da_q[0];
		qa1.neg = g3.qneg;
		qa1.ovf = da_ovf[1];
		qa1.q   = da_q[1];
		// bearing over px is minus py over c1
		qa2.neg = !g3.qneg;
		qa2.ovf = da_ovf[2];
		qa2.q   = da_q[2];
		qa3.neg = g3.pneg;
		qa3.ovf = da_ovf[3];
		qa3.q   = da_q[3];
		neg4    = rmj_pkg::quo_is_neg(qa1) != g3.dneg;
		neg5    = rmj_pkg::quo_is_neg(qa0) != (!g3.dneg && (g3.ad != '0));
		mid_in.near = g3.near;
		mid_in.e0   = qa0;
		mid_in.e1   = qa1;
		mid_in.e2   = qa2;
		mid_in.e3   = qa3;
		mid_in.c1   = g3.c1;
		mid_in.neg5 = neg5;
	end

	// |range_d| times |d|
	logic             m0_valid;
	logic [PW-1:0]    m0_prod, m1_prod;
	logic [MID_W-1:0] m0_side;
	logic             m1_side;
	rmj_pkg::mid_t    mid_out;

	rmj_wmul #(.SW(MID_W)) u_mul_e0 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (da_valid),
		.a         (rmj_pkg::quo_mag(qa0)),
		.b         (g3.ad),
		.in_side   (mid_in),
		.out_valid (m0_valid),
		.prod      (m0_prod),
		.out_side  (m0_side)
	);

	rmj_wmul #(.SW(1)) u_mul_e1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (da_valid),
		.a         (rmj_pkg::quo_mag(qa1)),
		.b         (g3.ad),
		.in_side   (neg4),
		.out_valid (),
		.prod      (m1_prod),
		.out_side  (m1_side)
	);

	// range-rate divides by c1
	rmj_pkg::fin_t    fin_in, fin_out;
	logic [FIN_W-1:0] fin_vec;
	logic             db_valid;
	logic             db4_ovf, db5_ovf;
	logic [QW-1:0]    db4_q, db5_q;
	logic             db4_neg;

	always_comb begin
		mid_out     = rmj_pkg::mid_t'(m0_side);
		fin_in.near = mid_out.near;
		fin_in.e0   = mid_out.e0;
		fin_in.e1   = mid_out.e1;
		fin_in.e2   = mid_out.e2;
		fin_in.e3   = mid_out.e3;
		fin_in.neg5 = mid_out.neg5;
	end

	rmj_div #(.NW(PW), .DW(WW), .SW(FIN_W)) u_div_e5 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (m0_valid),
		.num       (m0_prod),
		.den       (mid_out.c1),
		.in_side   (fin_in),
		.out_valid (db_valid),
		.out_ovf   (db5_ovf),
		.out_q     (db5_q),
		.out_side  (fin_vec)
	);

	rmj_div #(.NW(PW), .DW(WW), .SW(1)) u_div_e4 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (m0_valid),
		.num       (m1_prod),
		.den       (mid_out.c1),
		.in_side   (m1_side),
		.out_valid (),
		.out_ovf   (db4_ovf),
		.out_q     (db4_q),
		.out_side  (db4_neg)
	);

	// saturate, apply the near-zero suppression, register the result
	rmj_pkg::quo_t qb4, qb5;
	rmj_pkg::jac_t jac_n;

	always_comb begin
		fin_out = rmj_pkg::fin_t'(fin_vec);
		qb4.neg = db4_neg;
		qb4.ovf = db4_ovf;
		qb4.q   = db4_q;
		qb5.neg = fin_out.neg5;
		qb5.ovf = db5_ovf;
		qb5.q   = db5_q;
		if (fin_out.near) begin
			jac_n           = '0;
			jac_n.near_zero = 1'b1;
		end else begin
			jac_n.range_d_px   = rmj_pkg::quo_sat(fin_out.e0);
			jac_n.range_d_py   = rmj_pkg::quo_sat(fin_out.e1);
			jac_n.bearing_d_px = rmj_pkg::quo_sat(fin_out.e2);
			jac_n.bearing_d_py = rmj_pkg::quo_sat(fin_out.e3);
			jac_n.rate_d_px    = rmj_pkg::quo_sat(qb4);
			jac_n.rate_d_py    = rmj_pkg::quo_sat(qb5);
			jac_n.rate_d_vx    = rmj_pkg::quo_sat(fin_out.e0);
			jac_n.rate_d_vy    = rmj_pkg::quo_sat(fin_out.e1);
			jac_n.near_zero    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jac_valid_q <= 1'b0;
		end else if (adv) begin
			jac_valid_q <= db_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			jac_q <= jac_n;
		end
	end

endmodule

FILE: dv/tb.sv
// tb: self-checking testbench for radar_measurement_jacobian, directed table then random states
// across several near-zero thresholds; depends on rmj_pkg and the rtl of the block
module tb;

	localparam int LATENCY   = 101;
	localparam int CYCLE_CAP = 1000000;
	localparam int N_PHASE   = 6;
	localparam int PER_PHASE = 300;
	localparam int FRAC_W    = 16;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            state_valid = 1'b0;
	logic            state_stall;
	rmj_pkg::state_t state = '0;
	logic            jac_valid;
	logic            jac_stall = 1'b0;
	rmj_pkg::jac_t   jac;
	logic            thr_valid = 1'b0;
	logic            thr_ready;
	logic [31:0]     thr_data = '0;

	// expected jacobians, oldest first
	rmj_pkg::jac_t jac_pending[$];
	logic [31:0]   thr_cur;
	int            mismatches = 0;
	int            cycles = 0;
	bit            quiet = 1'b0;
	bit            hold_req = 1'b0;

	typedef struct {
		bit              is_cfg;
		logic [31:0]     thr;
		rmj_pkg::state_t s;
		bit              typed;
		rmj_pkg::jac_t   exp;
	} row_t;
	row_t rows[$];

	radar_measurement_jacobian dut (
		.clk(clk), .arst_n(arst_n),
		.state_valid(state_valid), .state_stall(state_stall), .state(state),
		.jac_valid(jac_valid), .jac_stall(jac_stall), .jac(jac),
		.thr_valid(thr_valid), .thr_ready(thr_ready), .thr_data(thr_data)
	);

	always #2 clk = ~clk;

	// integer square root, floor
	function automatic logic [63:0] root64(logic [63:0] x);
		logic [63:0] r, b;
		r = '0;
		b = 64'h1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// sign and magnitude to saturated 32-bit entry
	function automatic logic [31:0] clamp32(bit neg, logic [127:0] mag);
		logic [31:0] v;
		if (neg) begin
			v = (mag >= 128'h8000_0000) ? 32'h8000_0000 : -mag[31:0];
		end else begin
			v = (mag > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
		end
		return v;
	endfunction

	function automatic rmj_pkg::jac_t jacobian_of(rmj_pkg::state_t s, logic [31:0] thr);
		logic signed [65:0] p, q, u, v, d;
		logic [63:0]        ap, aq, c1, r;
		logic [65:0]        dm;
		logic [32:0]        m0, m1;
		logic [127:0]       c1w;
		logic signed [31:0] e0, e1, e2, e3, e4, e5;
		rmj_pkg::jac_t      j;
		p = s.pos_x;
		q = s.pos_y;
		u = s.vel_x;
		v = s.vel_y;
		ap = (p < 0) ? 64'(-p) : 64'(p);
		aq = (q < 0) ? 64'(-q) : 64'(q);
		c1 = ap * ap + aq * aq;
		j = '0;
		if (c1 <= ({32'b0, thr} << FRAC_W)) begin
			j.near_zero = 1'b1;
			return j;
		end
		r = root64(c1);
		c1w = {64'b0, c1};
		e0 = clamp32(p < 0, ({64'b0, ap} << FRAC_W) / {64'b0, r});
		e1 = clamp32(q < 0, ({64'b0, aq} << FRAC_W) / {64'b0, r});
		e2 = clamp32(q > 0, ({64'b0, aq} << (2 * FRAC_W)) / c1w);
		e3 = clamp32(p < 0, ({64'b0, ap} << (2 * FRAC_W)) / c1w);
		// range-rate numerator, exact
		d = u * q - v * p;
		dm = (d < 0) ? -d : d;
		m0 = (e0 < 0) ? -{e0[31], e0} : {1'b0, e0};
		m1 = (e1 < 0) ? -{e1[31], e1} : {1'b0, e1};
		e4 = clamp32((e1 < 0) != (d < 0), ({95'b0, m1} * {62'b0, dm}) / c1w);
		e5 = clamp32((e0 < 0) != (d > 0), ({95'b0, m0} * {62'b0, dm}) / c1w);
		j.range_d_px   = e0;
		j.range_d_py   = e1;
		j.bearing_d_px = e2;
		j.bearing_d_py = e3;
		j.rate_d_px    = e4;
		j.rate_d_py    = e5;
		j.rate_d_vx    = e0;
		j.rate_d_vy    = e1;
		return j;
	endfunction

	function automatic rmj_pkg::state_t mk(logic [31:0] px, logic [31:0] py,
			logic [31:0] vx, logic [31:0] vy);
		rmj_pkg::state_t s;
		s.pos_x = px;
		s.pos_y = py;
		s.vel_x = vx;
		s.vel_y = vy;
		return s;
	endfunction

	function automatic rmj_pkg::jac_t mkj(logic [31:0] a, logic [31:0] b, logic [31:0] c,
			logic [31:0] e, logic [31:0] f, logic [31:0] g, logic [31:0] h,
			logic [31:0] k, logic nz);
		rmj_pkg::jac_t j;
		j = {a, b, c, e, f, g, h, k, nz};
		return j;
	endfunction

	task automatic add_state(rmj_pkg::state_t s);
		rows.push_back('{1'b0, 32'd0, s, 1'b0, rmj_pkg::jac_t'('0)});
	endtask

	task automatic add_typed(rmj_pkg::state_t s, rmj_pkg::jac_t e);
		rows.push_back('{1'b0, 32'd0, s, 1'b1, e});
	endtask

	task automatic add_cfg(logic [31:0] v);
		rows.push_back('{1'b1, v, rmj_pkg::state_t'('0), 1'b0, rmj_pkg::jac_t'('0)});
	endtask

	// offer one state, with an optional gap first, and record its expectation on acceptance
	task automatic offer_state(rmj_pkg::state_t s, bit typed, rmj_pkg::jac_t e);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			state_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		state_valid <= 1'b1;
		state       <= s;
		do @(posedge clk); while (state_stall);
		jac_pending.push_back(typed ? e : jacobian_of(s, thr_cur));
	endtask

	// pipeline drained, then the register write
	task automatic write_threshold(logic [31:0] v);
		state_valid <= 1'b0;
		do @(posedge clk); while (jac_pending.size() != 0);
		repeat (LATENCY + 10) @(posedge clk);
		thr_valid <= 1'b1;
		thr_data  <= v;
		do @(posedge clk); while (!thr_ready);
		thr_valid <= 1'b0;
		thr_cur = v;
	endtask

	function automatic logic [31:0] rnd_field(int kind);
		logic [31:0] v;
		case (kind)
			0: begin
				v = $urandom;
			end
			1: begin
				// small magnitudes, a few units
				v = $urandom_range(0, 32'h000F_FFFF);
				if ($urandom_range(0, 1)) v = -v;
			end
			2: begin
				// close to the origin, around the threshold
				v = $urandom_range(0, 3000);
				if ($urandom_range(0, 1)) v = -v;
			end
			default: begin
				case ($urandom_range(0, 5))
					0: v = 32'h8000_0000;
					1: v = 32'h7FFF_FFFF;
					2: v = 32'h0000_0000;
					3: v = 32'h0000_0001;
					4: v = 32'hFFFF_FFFF;
					default: v = 32'h0001_0000;
				endcase
			end
		endcase
		return v;
	endfunction

	// output side: every transaction checked against the oldest expectation
	always @(posedge clk) begin
		rmj_pkg::jac_t want;
		if (arst_n && jac_valid && !jac_stall) begin
			if (jac_pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected jacobian %h", jac);
			end else begin
				want = jac_pending.pop_front();
				if (jac !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("jacobian mismatch for entries px py vx vy and flag:");
						$display("  exp %h %h %h %h %h %h %h %h %b", want.range_d_px,
							want.range_d_py, want.bearing_d_px, want.bearing_d_py,
							want.rate_d_px, want.rate_d_py, want.rate_d_vx,
							want.rate_d_vy, want.near_zero);
						$display("  got %h %h %h %h %h %h %h %h %b", jac.range_d_px,
							jac.range_d_py, jac.bearing_d_px, jac.bearing_d_py,
							jac.rate_d_px, jac.rate_d_py, jac.rate_d_vx,
							jac.rate_d_vy, jac.near_zero);
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// receiver: random stall bursts, one long hold-off on request, none when quiet
	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				jac_stall <= 1'b1;
				repeat (400) @(posedge clk);
				hold_req = 1'b0;
			end else if (quiet) begin
				jac_stall <= 1'b0;
				@(posedge clk);
			end else begin
				jac_stall <= ($urandom_range(0, 2) == 0);
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
		end
	end

	initial begin
		rmj_pkg::state_t s;
		logic [31:0] t;
		int k;
		thr_cur = 32'd66;

		// after reset the threshold is 66
		add_typed(mk(0, 0, 0, 0), mkj(0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
		add_typed(mk(32'h0001_0000, 0, 0, 0),
			mkj(32'h0001_0000, 0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000, 0, 1'b0));
		add_typed(mk(0, 32'h0001_0000, 0, 0),
			mkj(0, 32'h0001_0000, 32'hFFFF_0000, 0, 0, 0, 0, 32'h0001_0000, 1'b0));
		add_state(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		add_state(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		add_state(mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
		add_state(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
		add_state(mk(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000));
		add_state(mk(32'h0003_0000, 32'hFFFC_0000, 32'hFFFF_FFFF, 32'h0000_0001));
		// threshold zero: only the origin is suppressed, tiny inputs saturate
		add_cfg(32'd0);
		add_typed(mk(0, 0, 32'h7FFF_FFFF, 32'h8000_0000), mkj(0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
		add_typed(mk(1, 0, 0, 0),
			mkj(32'h0001_0000, 0, 0, 32'h7FFF_FFFF, 0, 0, 32'h0001_0000, 0, 1'b0));
		add_state(mk(0, 32'hFFFF_FFFF, 5, 0));
		// threshold one: boundary exactly at unit radius
		add_cfg(32'h0001_0000);
		add_typed(mk(32'h0001_0000, 0, 3, 3), mkj(0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
		add_typed(mk(0, 32'hFFFF_0000, 3, 3), mkj(0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
		add_state(mk(32'h0001_0001, 0, 32'h0000_1234, 32'hFFFF_1234));
		// largest threshold
		add_cfg(32'hFFFF_FFFF);
		add_state(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		add_state(mk(32'h0100_0000, 0, 32'h0000_0100, 32'h0000_0100));
		add_state(mk(32'h8000_0000, 0, 0, 32'h8000_0000));
		add_state(mk(32'h00FF_FFFF, 0, 0, 0));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].is_cfg) write_threshold(rows[i].thr);
			else offer_state(rows[i].s, rows[i].typed, rows[i].exp);
		end

		for (int ph = 0; ph < N_PHASE; ph++) begin
			case (ph)
				0: t = 32'd66;
				1: t = $urandom;
				2: t = 32'd0;
				3: t = 32'hFFFF_FFFF;
				4: t = $urandom_range(0, 4096);
				default: t = 32'd66;
			endcase
			write_threshold(t);
			// long hold-off at the output while states keep coming
			if (ph == 1) hold_req = 1'b1;
			if (ph == N_PHASE - 1) quiet = 1'b1;
			for (int n = 0; n < PER_PHASE; n++) begin
				k = $urandom_range(0, 9);
				if (k <= 3) k = 0;
				else if (k <= 5) k = 1;
				else if (k <= 7) k = 2;
				else k = 3;
				s = mk(rnd_field(k), rnd_field(k), rnd_field($urandom_range(0, 3)),
					rnd_field($urandom_range(0, 3)));
				// points on an axis
				if ($urandom_range(0, 15) == 0) s.pos_x = '0;
				if ($urandom_range(0, 15) == 0) s.pos_y = '0;
				offer_state(s, 1'b0, rmj_pkg::jac_t'('0));
			end
		end

		state_valid <= 1'b0;
		do @(posedge clk); while (jac_pending.size() != 0);
		repeat (LATENCY + 20) @(posedge clk);
		if (mismatches == 0 && jac_pending.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

FILE: radar_measurement_jacobian.f
rtl/core/rmj_pkg.sv
rtl/core/rmj_sqrt.sv
rtl/core/rmj_div.sv
rtl/core/rmj_wmul.sv
rtl/core/radar_measurement_jacobian.sv
dv/tb.sv
